// ----- rtl/hufd_pkg.sv -----
// Shared types and constants of the tree-walk decoder.
`timescale 1ns / 1ps
package hufd_pkg;

   // Field widths
   localparam int IDX_W  = 9;
   localparam int SYM_W  = 8;
   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;

   // Default size of the node store
   localparam int NODE_COUNT_DEF = 512;

   // Bit counter for one compressed byte
   localparam int BIT_CNT_W = $clog2(BYTE_W + 1);
   localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = BIT_CNT_W'(BYTE_W);

   // Queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   // Command codes on the input channel
   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE   = 2'd0,
      CMD_DECODE  = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   // Item kinds after classification
   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_DECODE,
      KIND_RESTART
   } kind_type;

   // One node store entry
   typedef struct packed {
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic             leaf;
      logic [SYM_W-1:0] sym;
   } node_type;

   // One classified item in the queue
   typedef struct packed {
      kind_type          kind;
      logic [IDX_W-1:0]  index;
      node_type          node;
      logic [BYTE_W-1:0] code;
   } item_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READY,
      ST_ROOT_LOAD,
      ST_CUR_LOAD,
      ST_BIT,
      ST_ARRIVE,
      ST_FLUSH
   } state_type;

   // Back-end status seen by the top level
   typedef struct packed {
      logic busy;
      logic pend_valid;
   } back_status_type;

endpackage

// ----- rtl/hufd_front.sv -----
// Front end: accept input items, classify them and feed the queue.
`timescale 1ns / 1ps
module hufd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hufd_pkg::CMD_W-1:0]    req_command,
   input  logic [hufd_pkg::IDX_W-1:0]    req_node_index,
   input  logic [hufd_pkg::IDX_W-1:0]    req_left_child,
   input  logic [hufd_pkg::IDX_W-1:0]    req_right_child,
   input  logic                          req_leaf_flag,
   input  logic [hufd_pkg::SYM_W-1:0]    req_node_symbol,
   input  logic [hufd_pkg::BYTE_W-1:0]   req_code_byte,
   input  logic                          q_full,
   output logic                          q_push,
   output hufd_pkg::item_type            q_item
);

   logic               item_v_ff;
   logic               item_v_in;
   hufd_pkg::item_type item_ff;
   hufd_pkg::item_type item_in;
   logic               known;

   // Hold the input while the staged item cannot enter the queue
   assign req_stall = item_v_ff && q_full;
   assign q_push    = item_v_ff && !q_full;
   assign q_item    = item_ff;

   // Classify the command; drop unknown codes
   always_comb begin
      item_in.index      = req_node_index;
      item_in.node.left  = req_left_child;
      item_in.node.right = req_right_child;
      item_in.node.leaf  = req_leaf_flag;
      item_in.node.sym   = req_node_symbol;
      item_in.code       = req_code_byte;
      item_in.kind       = hufd_pkg::KIND_WRITE;
      known              = 1'b1;
      unique case (hufd_pkg::cmd_type'(req_command))
         hufd_pkg::CMD_WRITE:   item_in.kind = hufd_pkg::KIND_WRITE;
         hufd_pkg::CMD_DECODE:  item_in.kind = hufd_pkg::KIND_DECODE;
         hufd_pkg::CMD_RESTART: item_in.kind = hufd_pkg::KIND_RESTART;
         default:               known = 1'b0;
      endcase
      if (req_stall) begin
         item_v_in = item_v_ff;
      end else begin
         item_v_in = req_valid && known;
      end
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_v_ff <= 1'b0;
      end else begin
         item_v_ff <= item_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- rtl/hufd_queue.sv -----
// Short item queue between the front end and the back end.
`timescale 1ns / 1ps
module hufd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hufd_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output hufd_pkg::item_type pop_item
);

   hufd_pkg::item_type                 entries_ff [hufd_pkg::Q_DEPTH];
   logic [hufd_pkg::Q_PTR_W-1:0]       wr_ptr_ff;
   logic [hufd_pkg::Q_PTR_W-1:0]       rd_ptr_ff;
   logic [hufd_pkg::Q_CNT_W-1:0]       count_ff;
   logic [hufd_pkg::Q_CNT_W-1:0]       count_in;

   assign full      = (count_ff == hufd_pkg::Q_CNT_W'(hufd_pkg::Q_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entries_ff[rd_ptr_ff];

   // Track the fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + hufd_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - hufd_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + hufd_pkg::Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + hufd_pkg::Q_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/hufd_back.sv -----
// Back end: node store, bit-by-bit tree walk and result register.
`timescale 1ns / 1ps
module hufd_back #(
   parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [hufd_pkg::IDX_W-1:0]    csr_write_data,
   input  logic                          q_valid,
   input  hufd_pkg::item_type            q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hufd_pkg::SYM_W-1:0]    rsp_symbol,
   output logic                          rsp_last,
   output hufd_pkg::back_status_type     status
);

   localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int EXT_W  = (ADDR_W > hufd_pkg::IDX_W) ? ADDR_W : hufd_pkg::IDX_W;

   function automatic logic [ADDR_W-1:0] to_addr(input logic [hufd_pkg::IDX_W-1:0] idx);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(idx);
      return ext[ADDR_W-1:0];
   endfunction

   function automatic logic in_range(input logic [hufd_pkg::IDX_W-1:0] idx);
      return (32'(idx) < 32'(NODE_COUNT));
   endfunction

   // Node store and its registered read port
   hufd_pkg::node_type               node_mem [NODE_COUNT];
   hufd_pkg::node_type               rd_data_ff;
   logic                             rd_zero_ff;
   logic                             rd_en;
   logic [hufd_pkg::IDX_W-1:0]       rd_idx;
   logic                             wr_en;
   hufd_pkg::node_type               mem_ent;

   // Sequencer state
   hufd_pkg::state_type              state_ff, state_in;
   logic [hufd_pkg::IDX_W-1:0]       root_ff, root_in;
   logic [hufd_pkg::IDX_W-1:0]       walk_ff, walk_in;
   logic                             src_root_ff, src_root_in;
   logic                             root_ok_ff, root_ok_in;
   logic                             cur_ok_ff, cur_ok_in;
   hufd_pkg::node_type               root_ent_ff, root_ent_in;
   logic [hufd_pkg::BYTE_W-1:0]      code_ff, code_in;
   logic [hufd_pkg::BIT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                             pend_v_ff, pend_v_in;
   logic [hufd_pkg::SYM_W-1:0]       pend_sym_ff, pend_sym_in;
   logic                             out_v_ff, out_v_in;
   logic [hufd_pkg::SYM_W-1:0]       out_sym_ff, out_sym_in;
   logic                             out_last_ff, out_last_in;

   // Walk helpers
   hufd_pkg::node_type               cur;
   logic [hufd_pkg::IDX_W-1:0]       child;
   logic                             out_free;
   logic                             can_emit;
   logic                             emit;
   logic [hufd_pkg::SYM_W-1:0]       emit_sym;
   logic                             flush;

   assign mem_ent  = rd_zero_ff ? '0 : rd_data_ff;
   assign cur      = src_root_ff ? root_ent_ff : mem_ent;
   assign child    = code_ff[hufd_pkg::BYTE_W-1] ? cur.right : cur.left;
   assign out_free = !out_v_ff || !rsp_stall;
   assign can_emit = !pend_v_ff || out_free;

   assign rsp_valid         = out_v_ff;
   assign rsp_symbol        = out_sym_ff;
   assign rsp_last          = out_last_ff;
   assign status.busy       = (state_ff != hufd_pkg::ST_IDLE);
   assign status.pend_valid = pend_v_ff;

   // Next state and outputs
   always_comb begin
      state_in    = state_ff;
      root_in     = root_ff;
      walk_in     = walk_ff;
      src_root_in = src_root_ff;
      root_ok_in  = root_ok_ff;
      cur_ok_in   = cur_ok_ff;
      root_ent_in = root_ent_ff;
      code_in     = code_ff;
      cnt_in      = cnt_ff;
      pend_v_in   = pend_v_ff;
      pend_sym_in = pend_sym_ff;
      out_v_in    = out_v_ff && rsp_stall;
      out_sym_in  = out_sym_ff;
      out_last_in = out_last_ff;
      rd_en       = 1'b0;
      rd_idx      = walk_ff;
      wr_en       = 1'b0;
      q_pop       = 1'b0;
      emit        = 1'b0;
      emit_sym    = cur.sym;
      flush       = 1'b0;

      unique case (state_ff)
         hufd_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.kind)
                  hufd_pkg::KIND_WRITE: begin
                     if (in_range(q_item.index)) begin
                        wr_en = 1'b1;
                        if (q_item.index == root_ff) begin
                           root_ent_in = q_item.node;
                        end
                     end
                     cur_ok_in = 1'b0;
                  end
                  hufd_pkg::KIND_RESTART: begin
                     walk_in     = root_ff;
                     src_root_in = 1'b1;
                  end
                  hufd_pkg::KIND_DECODE: begin
                     code_in  = q_item.code;
                     cnt_in   = hufd_pkg::BITS_PER_BYTE;
                     state_in = hufd_pkg::ST_READY;
                  end
                  default: ;
               endcase
            end
         end
         // Make sure the root entry and the current entry are on hand
         hufd_pkg::ST_READY: begin
            if (!root_ok_ff) begin
               rd_en    = 1'b1;
               rd_idx   = root_ff;
               state_in = hufd_pkg::ST_ROOT_LOAD;
            end else if (!src_root_ff && !cur_ok_ff) begin
               rd_en    = 1'b1;
               rd_idx   = walk_ff;
               state_in = hufd_pkg::ST_CUR_LOAD;
            end else begin
               state_in = hufd_pkg::ST_BIT;
            end
         end
         hufd_pkg::ST_ROOT_LOAD: begin
            root_ent_in = mem_ent;
            root_ok_in  = 1'b1;
            cur_ok_in   = 1'b0;
            state_in    = hufd_pkg::ST_READY;
         end
         hufd_pkg::ST_CUR_LOAD: begin
            cur_ok_in = 1'b1;
            state_in  = hufd_pkg::ST_BIT;
         end
         // Take one bit from the current node
         hufd_pkg::ST_BIT: begin
            if (cur.leaf) begin
               if (can_emit) begin
                  emit        = 1'b1;
                  emit_sym    = cur.sym;
                  walk_in     = root_ff;
                  src_root_in = 1'b1;
                  cnt_in      = cnt_ff - hufd_pkg::BIT_CNT_W'(1);
                  code_in     = code_ff << 1;
                  state_in    = (cnt_ff == hufd_pkg::BIT_CNT_W'(1)) ?
                                hufd_pkg::ST_FLUSH : hufd_pkg::ST_BIT;
               end
            end else begin
               rd_en       = 1'b1;
               rd_idx      = child;
               walk_in     = child;
               src_root_in = 1'b0;
               cur_ok_in   = 1'b0;
               cnt_in      = cnt_ff - hufd_pkg::BIT_CNT_W'(1);
               code_in     = code_ff << 1;
               state_in    = hufd_pkg::ST_ARRIVE;
            end
         end
         // Check the node just reached; step on at once if it is inner and bits remain
         hufd_pkg::ST_ARRIVE: begin
            if (mem_ent.leaf) begin
               if (can_emit) begin
                  emit        = 1'b1;
                  emit_sym    = mem_ent.sym;
                  walk_in     = root_ff;
                  src_root_in = 1'b1;
                  state_in    = (cnt_ff == '0) ? hufd_pkg::ST_FLUSH : hufd_pkg::ST_BIT;
               end
            end else if (cnt_ff != '0) begin
               rd_en    = 1'b1;
               rd_idx   = child;
               walk_in  = child;
               cnt_in   = cnt_ff - hufd_pkg::BIT_CNT_W'(1);
               code_in  = code_ff << 1;
            end else begin
               cur_ok_in = 1'b1;
               state_in  = hufd_pkg::ST_FLUSH;
            end
         end
         // Release the held symbol as the final one of the byte
         hufd_pkg::ST_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = hufd_pkg::ST_IDLE;
            end else if (out_free) begin
               flush    = 1'b1;
               state_in = hufd_pkg::ST_IDLE;
            end
         end
         default: state_in = hufd_pkg::ST_IDLE;
      endcase

      // Hold one symbol back so the last mark can be set at byte end
      if (emit) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_sym_in  = pend_sym_ff;
            out_last_in = 1'b0;
         end
         pend_v_in   = 1'b1;
         pend_sym_in = emit_sym;
      end
      if (flush) begin
         out_v_in    = 1'b1;
         out_sym_in  = pend_sym_ff;
         out_last_in = 1'b1;
         pend_v_in   = 1'b0;
      end

      // Root register write moves the walk to the new root
      if (csr_write_enable) begin
         root_in     = csr_write_data;
         walk_in     = csr_write_data;
         src_root_in = 1'b1;
         root_ok_in  = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hufd_pkg::ST_IDLE;
         root_ff     <= '0;
         walk_ff     <= '0;
         src_root_ff <= 1'b1;
         root_ok_ff  <= 1'b0;
         cur_ok_ff   <= 1'b0;
         cnt_ff      <= '0;
         pend_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         root_ff     <= root_in;
         walk_ff     <= walk_in;
         src_root_ff <= src_root_in;
         root_ok_ff  <= root_ok_in;
         cur_ok_ff   <= cur_ok_in;
         cnt_ff      <= cnt_in;
         pend_v_ff   <= pend_v_in;
         out_v_ff    <= out_v_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      root_ent_ff <= root_ent_in;
      code_ff     <= code_in;
      pend_sym_ff <= pend_sym_in;
      out_sym_ff  <= out_sym_in;
      out_last_ff <= out_last_in;
   end

   // Node store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[to_addr(q_item.index)] <= q_item.node;
      end
      if (rd_en) begin
         rd_data_ff <= node_mem[to_addr(rd_idx)];
         rd_zero_ff <= !in_range(rd_idx);
      end
   end

endmodule

// ----- rtl/huffman_tree_walk_decoder_top.sv -----
// Huffman tree-walk decoder: front end, item queue and walking back end.
// An item passes the front-end stage register and the queue before the back end takes it.
// A decode byte is walked from its top bit, each child node read on the store's single read
// port; the root entry is reloaded after reset or a root write, a node write while the walk
// is below the root makes the current node be read again, and result stalls hold the walk.
// Write and restart finish in the idle state. Reset (synchronous, active high) empties the
// queue and results and sets root and walk to node 0; the store is not reset.
`timescale 1ns / 1ps
module huffman_tree_walk_decoder_top #(
   parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hufd_pkg::CMD_W-1:0]    req_command,
   input  logic [hufd_pkg::IDX_W-1:0]    req_node_index,
   input  logic [hufd_pkg::IDX_W-1:0]    req_left_child,
   input  logic [hufd_pkg::IDX_W-1:0]    req_right_child,
   input  logic                          req_leaf_flag,
   input  logic [hufd_pkg::SYM_W-1:0]    req_node_symbol,
   input  logic [hufd_pkg::BYTE_W-1:0]   req_code_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hufd_pkg::SYM_W-1:0]    rsp_symbol,
   output logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic [hufd_pkg::IDX_W-1:0]    csr_write_data
);

   logic                          q_push;
   logic                          q_full;
   hufd_pkg::item_type            q_push_item;
   logic                          q_pop;
   logic                          q_valid;
   hufd_pkg::item_type            q_pop_item;
   hufd_pkg::back_status_type     back_status;

   // Accept and classify
   hufd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_node_index  (req_node_index),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .req_leaf_flag   (req_leaf_flag),
      .req_node_symbol (req_node_symbol),
      .req_code_byte   (req_code_byte),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_push_item)
   );

   // Decouple the two sides
   hufd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_pop_item)
   );

   // Walk the tree
   hufd_back #(
      .NODE_COUNT (NODE_COUNT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_item           (q_pop_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol       (rsp_symbol),
      .rsp_last         (rsp_last),
      .status           (back_status)
   );

`ifndef NO_ASSERTIONS
   // The front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("item pushed into a full queue");

   // A held symbol is always flushed before the back end goes idle
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      !back_status.busy |-> !back_status.pend_valid)
      else $error("symbol left pending at end of byte");

   // The back end takes a new item only when idle
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> !q_pop)
      else $error("queue popped while a byte is in progress");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
